/* src/assert_macros.svh */
// assertion helpers used by xsr_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

/* src/xsr_pkg.sv */
`default_nettype none
package xsr_pkg;
	localparam logic [63:0] FALLBACK_SEED = 64'hDEADBEEFCAFEBABE;
	localparam logic [63:0] STAR_MULT = 64'h2545F4914F6CDD1D;
	localparam int FRAC_SHIFT = 11;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic OP_FRACTION = 1'b0;
	localparam logic OP_INTEGER = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
	} in_word_t;

	typedef struct packed {
		logic [52:0] fraction;
		logic signed [31:0] int_value;
		logic error;
	} out_word_t;

	// classified request handed from front to back
	typedef struct packed {
		logic op;
		logic error;
		logic signed [31:0] range_min;
		logic [32:0] size;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_DONE
	} back_state_t;

	function automatic logic [63:0] xs_step(input logic [63:0] s);
		logic [63:0] x;
		x = s ^ (s >> 12);
		x = x ^ (x << 25);
		x = x ^ (x >> 27);
		return x;
	endfunction
endpackage
`default_nettype wire

/* src/xsr_front.sv */
`default_nettype none
module xsr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire xsr_pkg::in_word_t in_word,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output xsr_pkg::cmd_t cmd
);
	import xsr_pkg::*;
	// one-entry stage between input and queue
	logic full_q;
	cmd_t cmd_q;
	logic signed [32:0] diff;

	assign diff = 33'(signed'(in_word.range_max)) - 33'(signed'(in_word.range_min));
	assign in_ready = !full_q || cmd_ready;
	assign cmd_valid = full_q;
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.op <= in_word.op;
			cmd_q.range_min <= in_word.range_min;
			cmd_q.error <= (in_word.op == OP_INTEGER) && diff[32];
			cmd_q.size <= 33'(diff) + 33'd1;
		end
	end
endmodule
`default_nettype wire

/* src/xsr_queue.sv */
`default_nettype none
module xsr_queue #(
	parameter int Depth = xsr_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire xsr_pkg::cmd_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output xsr_pkg::cmd_t rd_data
);
	import xsr_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	cmd_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

/* src/xsr_back.sv */
`default_nettype none
`include "assert_macros.svh"
module xsr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic seed_we,
	input wire logic [63:0] seed_data,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire xsr_pkg::cmd_t cmd,
	output logic out_valid,
	input wire logic out_ready,
	output xsr_pkg::out_word_t out_word
);
	import xsr_pkg::*;
	back_state_t state_q, state_d;
	logic [63:0] gen_q;
	cmd_t cur_q;
	logic [63:0] draw_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic [2:0] part_q;
	logic [63:0] mcand_q;
	logic [33:0] trial;
	logic [32:0] rem_sh;
	logic [63:0] pp;
	logic [31:0] mop;
	logic [15:0] mpl;
	logic [6:0] mul_sh;
	logic out_full_q;
	out_word_t out_q;
	logic take, mul_last, div_last;

	assign take = cmd_valid && cmd_ready;
	assign out_valid = out_full_q;
	assign out_word = out_q;
	assign mul_last = part_q == 3'd7;
	assign div_last = cnt_q == 6'd63;

	// 64x64 low product in eight 32x16 slices, one per cycle
	// slices shifted past bit 63 drop out of the sum
	assign mop = part_q[2] ? mcand_q[63:32] : mcand_q[31:0];
	assign mpl = STAR_MULT[16*part_q[1:0] +: 16];
	assign mul_sh = (part_q[2] ? 7'd32 : 7'd0) + {1'b0, part_q[1:0], 4'b0000};
	assign pp = 64'(mop) * 64'(mpl);

	// restoring divide, one dividend bit per cycle
	assign rem_sh = {rem_q[31:0], draw_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, cur_q.size};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take) state_d = cmd.error ? ST_DONE : ST_MUL;
			ST_MUL: if (mul_last) state_d = (cur_q.op == OP_INTEGER) ? ST_DIV : ST_DONE;
			ST_DIV: if (div_last) state_d = ST_DONE;
			ST_DONE: if (!out_full_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_q <= FALLBACK_SEED;
			out_full_q <= 1'b0;
			part_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (seed_we) gen_q <= (seed_data != '0) ? seed_data : FALLBACK_SEED;
			else if (take && !cmd.error) gen_q <= xs_step(gen_q);
			if (state_q == ST_MUL) part_q <= part_q + 3'd1;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 6'd1;
			if (state_q == ST_DONE && (!out_full_q || out_ready)) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
			mcand_q <= xs_step(gen_q);
			draw_q <= '0;
			rem_q <= '0;
		end else if (state_q == ST_MUL) begin
			draw_q <= draw_q + (pp << mul_sh);
			mcand_q <= mcand_q;
		end else if (state_q == ST_DIV) begin
			draw_q <= {draw_q[62:0], 1'b0};
			rem_q <= trial[33] ? rem_sh : trial[32:0];
		end
		if (state_q == ST_DONE && (!out_full_q || out_ready)) begin
			out_q.error <= cur_q.error;
			out_q.fraction <= (cur_q.op == OP_FRACTION) ? draw_q[63:FRAC_SHIFT] : '0;
			out_q.int_value <= (cur_q.op == OP_INTEGER && !cur_q.error)
				? cur_q.range_min + signed'(rem_q[31:0]) : '0;
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, cmd_ready, state_q == ST_IDLE)
	`ASSERT_NEXT(a_err_no_draw, clk, arst_n, take && cmd.error && !seed_we,
		gen_q == $past(gen_q))
	`ASSERT_IMPL(a_div_int, clk, arst_n, state_q == ST_DIV, cur_q.op == OP_INTEGER)
endmodule
`default_nettype wire

/* src/xorshift_star_random_unit.sv */
// the back end takes one request at a time: a fraction word runs the 32x16 multiplier slice
//   (8 passes), an integer word also runs the one-bit-per-cycle 64-step restoring divider,
//   and a range error skips both
// reset: arst_n clears all control state and loads the generator with the fallback seed
`default_nettype none
module xorshift_star_random_unit #(
	parameter int QueueDepth = xsr_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic seed_we,
	input wire logic [63:0] seed_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire xsr_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output xsr_pkg::out_word_t out_word
);
	import xsr_pkg::*;
	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	xsr_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_word,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

	xsr_queue #(.Depth(QueueDepth)) u_queue (.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd));

	xsr_back u_back (.clk, .arst_n, .seed_we, .seed_data,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid, .out_ready, .out_word);
endmodule
`default_nettype wire

/* dv/tb_xorshift_star_random_unit.sv */
`default_nettype none
module tb_xorshift_star_random_unit;
	import xsr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seed_we = 1'b0;
	logic [63:0] seed_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;

	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always #2 clk = ~clk;

	xorshift_star_random_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.seed_we(seed_we),
		.seed_data(seed_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	class draw_scoreboard;
		logic [63:0] gen_state;
		out_word_t pending[$];

		function void load_seed(logic [63:0] v);
			gen_state = (v != 0) ? v : 64'hDEADBEEFCAFEBABE;
		endfunction

		function logic [63:0] next_draw();
			logic [63:0] x;
			x = gen_state;
			x = x ^ (x >> 12);
			x = x ^ (x << 25);
			x = x ^ (x >> 27);
			gen_state = x;
			return x * 64'h2545F4914F6CDD1D;
		endfunction

		function void note_request(in_word_t w);
			out_word_t r;
			logic signed [63:0] lo, hi;
			logic [63:0] span;
			r = '0;
			if (w.op == OP_FRACTION) begin
				r.fraction = 53'(next_draw() >> 11);
			end else begin
				lo = w.range_min;
				hi = w.range_max;
				if (lo > hi) begin
					r.error = 1'b1;
				end else begin
					span = hi - lo + 1;
					r.int_value = 32'(lo + (next_draw() % span));
				end
			end
			pending.push_back(r);
		endfunction

		task check_result(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected word", 64'(got.fraction), 64'd0);
				return;
			end
			want = pending.pop_front();
			if (got.fraction !== want.fraction)
				report_mismatch("fraction", 64'(got.fraction), 64'(want.fraction));
			if (got.int_value !== want.int_value)
				report_mismatch("int_value", 64'(32'(got.int_value)),
					64'(32'(want.int_value)));
			if (got.error !== want.error)
				report_mismatch("error", 64'(got.error), 64'(want.error));
		endtask
	endclass

	draw_scoreboard draws = new();

	// receiver side: random stall, check on every accepted word
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && out_ready)
				draws.check_result(out_word);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// valid stays up after an accept; the idle loop or the caller drops it
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		draws.note_request(w);
	endtask

	task automatic write_seed(input logic [63:0] v);
		in_valid <= 1'b0;
		while (draws.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		seed_we <= 1'b1;
		seed_data <= v;
		@(posedge clk);
		seed_we <= 1'b0;
		draws.load_seed(v);
	endtask

	function automatic logic signed [31:0] pick_bound();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(20))) - 10;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send_one(input logic o, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		in_word_t w;
		w.op = o;
		w.range_min = lo;
		w.range_max = hi;
		send_word(w);
	endtask

	task automatic random_burst(input int n);
		logic signed [31:0] a, b;
		repeat (n) begin
			a = pick_bound();
			b = pick_bound();
			// mostly ordered ranges, some inverted
			if ($urandom_range(9) != 0 && a > b) begin
				a = a ^ b; b = a ^ b; a = a ^ b;
			end
			send_one(1'($urandom()), a, b);
		end
	endtask

	initial begin
		draws.load_seed(64'hDEADBEEFCAFEBABE);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both ops, extremes, errors, degenerate ranges
		send_one(OP_FRACTION, 32'sh7FFFFFFF, 32'sh80000000);
		send_one(OP_FRACTION, 0, 0);
		send_one(OP_INTEGER, 32'sh80000000, 32'sh7FFFFFFF);
		send_one(OP_INTEGER, 5, 5);
		send_one(OP_INTEGER, 32'sh80000000, 32'sh80000000);
		send_one(OP_INTEGER, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_one(OP_INTEGER, 32'sh7FFFFFFF, 32'sh80000000);
		send_one(OP_INTEGER, 1, 0);
		send_one(OP_INTEGER, -1, 0);
		send_one(OP_INTEGER, 0, 1);
		send_one(OP_FRACTION, 0, 0);
		write_seed(64'h0);
		send_one(OP_FRACTION, 0, 0);
		send_one(OP_INTEGER, -100, 100);
		write_seed(64'hFFFFFFFFFFFFFFFF);
		send_one(OP_FRACTION, 0, 0);
		send_one(OP_INTEGER, 32'sh80000000, 32'sh7FFFFFFF);
		write_seed(64'h1);
		send_one(OP_FRACTION, 0, 0);
		send_one(OP_INTEGER, 0, 32'sh7FFFFFFF);

		random_burst(300);
		write_seed({$urandom(), $urandom()});
		send_idle_pct = 59;
		random_burst(300);
		write_seed(64'h0);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		random_burst(300);
		write_seed({$urandom(), $urandom()});
		send_idle_pct = 13;
		recv_stall_pct = 13;
		random_burst(300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_burst(300);
		in_valid <= 1'b0;

		while (draws.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && draws.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
